[rtl/core/sorted_cursor_list_engine_unit_assert.svh]
// Assertion macros for the sorted cursor list engine.
// Used by the port checker; needs nothing else.
`ifndef SORTED_CURSOR_LIST_ENGINE_UNIT_ASSERT_SVH
`define SORTED_CURSOR_LIST_ENGINE_UNIT_ASSERT_SVH

// Check an implication that holds in the same cycle.
`define SCLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication that must hold in the next cycle.
`define SCLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/scle_pkg.sv]
// Shared types and constants for the sorted cursor list engine.
// No dependencies.
package scle_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_BITS = 8;
  localparam int MASK_W   = 25;
  localparam int SIZE_W   = 5;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_HEAD   = 3'd3,
    REQ_TAIL   = 3'd4,
    REQ_PREV   = 3'd5,
    REQ_NEXT   = 3'd6
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCUR = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [MASK_W-1:0]   mask;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  // Command from control to the row of cells
  typedef struct packed {
    logic             ins;
    logic             rem;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cursor;
  } chain_cmd_t;

  // Per-cell view of the command
  typedef struct packed {
    logic ins;
    logic rem;
    logic in_list;
    logic past_cur;
  } cell_ctl_t;

endpackage

[rtl/core/scle_cell.sv]
// One slot of the sorted list: holds an entry and trades it with its neighbors.
// Depends on scle_pkg.
module scle_cell (
  input  logic             clk,
  input  scle_pkg::cell_ctl_t ctl,
  input  scle_pkg::entry_t new_entry,
  input  scle_pkg::entry_t left_entry,
  input  scle_pkg::entry_t right_entry,
  input  logic             left_ge,
  output scle_pkg::entry_t entry_q,
  output logic             ge
);
  import scle_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // slots past the end count as greater, so the insert point is the first ge
  assign ge      = !ctl.in_list || (entry_r.key >= new_entry.key);
  assign entry_q = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (left_ge) begin
        entry_nxt = left_entry;
      end else if (ge) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.rem && ctl.past_cur) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/core/scle_chain.sv]
// Row of list cells plus the read port at the cursor.
// Depends on scle_pkg and scle_cell.
module scle_chain (
  input  logic                 clk,
  input  scle_pkg::chain_cmd_t cmd,
  output scle_pkg::entry_t     rd_entry
);
  import scle_pkg::*;

  entry_t q  [CAPACITY];
  logic   ge [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    left_e;
    entry_t    right_e;
    logic      left_g;

    assign ctl.ins      = cmd.ins;
    assign ctl.rem      = cmd.rem;
    assign ctl.in_list  = CNT_W'(i) < cmd.count;
    assign ctl.past_cur = CNT_W'(i) >= cmd.cursor;

    if (i == 0) begin : g_head
      assign left_e = cmd.new_entry;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = q[i-1];
      assign left_g = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = q[i];
    end else begin : g_body
      assign right_e = q[i+1];
    end

    scle_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (cmd.new_entry),
      .left_entry (left_e),
      .right_entry(right_e),
      .left_ge    (left_g),
      .entry_q    (q[i]),
      .ge         (ge[i])
    );
  end

  assign rd_entry = q[cmd.cursor[IDX_W-1:0]];

endmodule

[rtl/core/sorted_cursor_list_engine_unit.sv]
// Top level of the sorted cursor list engine: request decode, count and cursor.
// Depends on scle_pkg and scle_chain.
//
//   channel   ports                               handshake
//   input     in_req_type in_new_key in_new_mask  start, taken when busy is low
//             in_new_size
//   result    out_status ... out_cur_size         out_strobe, one cycle
//
// A request is taken at an edge with start high and busy low; all cells shift
// or load in that same edge. The next cycle shows the result with out_strobe
// high and busy high; the result is the read of the updated cell row at the
// cursor. rst_n (synchronous) empties the list and puts the cursor off the
// list. The receiver cannot stall; no result is held.
module sorted_cursor_list_engine_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [scle_pkg::REQ_W-1:0]    in_req_type,
  input  logic [scle_pkg::KEY_BITS-1:0] in_new_key,
  input  logic [scle_pkg::MASK_W-1:0]   in_new_mask,
  input  logic [scle_pkg::SIZE_W-1:0]   in_new_size,
  output logic                          out_strobe,
  output logic [scle_pkg::STATUS_W-1:0] out_status,
  output logic                          out_cursor_valid,
  output logic [scle_pkg::IDX_W-1:0]    out_cursor_pos,
  output logic [scle_pkg::CNT_W-1:0]    out_entry_count,
  output logic [scle_pkg::KEY_BITS-1:0] out_cur_key,
  output logic [scle_pkg::MASK_W-1:0]   out_cur_mask,
  output logic [scle_pkg::SIZE_W-1:0]   out_cur_size
);
  import scle_pkg::*;

  logic             done_r;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [CNT_W-1:0] cur_r,    cur_nxt;
  logic             neg_r,    neg_nxt;
  status_t          status_r, status_nxt;
  logic             accept;
  logic             cur_ok;
  logic             ins, rem;
  chain_cmd_t       cmd;
  entry_t           rd_entry;

  assign accept = start && !busy;
  assign cur_ok = !neg_r && (cur_r < count_r);

  always_comb begin
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    neg_nxt    = neg_r;
    status_nxt = ST_OK;
    ins        = 1'b0;
    rem        = 1'b0;
    case (req_t'(in_req_type))
      REQ_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          ins       = 1'b1;
          count_nxt = count_r + 1'b1;
          cur_nxt   = count_r;
          neg_nxt   = 1'b0;
        end
      end
      REQ_REMOVE: begin
        if (cur_ok) begin
          rem       = 1'b1;
          count_nxt = count_r - 1'b1;
          // pull the cursor back when it was on the last entry
          if ((cur_r == count_r - 1'b1) && (count_r > CNT_W'(1))) begin
            cur_nxt = count_r - CNT_W'(2);
          end
        end else begin
          status_nxt = ST_NOCUR;
        end
      end
      REQ_READ: begin
        if (!cur_ok) status_nxt = ST_NOCUR;
      end
      REQ_HEAD: begin
        if (count_r != '0) begin
          cur_nxt = '0;
          neg_nxt = 1'b0;
        end else begin
          status_nxt = ST_NOCUR;
        end
      end
      REQ_TAIL: begin
        if (count_r != '0) begin
          cur_nxt = count_r - 1'b1;
          neg_nxt = 1'b0;
        end else begin
          status_nxt = ST_NOCUR;
        end
      end
      REQ_PREV: begin
        if (cur_ok) begin
          if (cur_r == '0) begin
            neg_nxt = 1'b1;
          end else begin
            cur_nxt = cur_r - 1'b1;
          end
        end else begin
          status_nxt = ST_NOCUR;
        end
      end
      REQ_NEXT: begin
        if (cur_ok) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          status_nxt = ST_NOCUR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= 1'b0;
      count_r  <= '0;
      cur_r    <= '0;
      neg_r    <= 1'b1;
      status_r <= ST_OK;
    end else begin
      done_r <= accept;
      if (accept) begin
        count_r  <= count_nxt;
        cur_r    <= cur_nxt;
        neg_r    <= neg_nxt;
        status_r <= status_nxt;
      end
    end
  end

  assign cmd.ins            = accept && ins;
  assign cmd.rem            = accept && rem;
  assign cmd.new_entry.key  = in_new_key;
  assign cmd.new_entry.mask = in_new_mask;
  assign cmd.new_entry.size = in_new_size;
  assign cmd.count          = count_r;
  assign cmd.cursor         = cur_r;

  scle_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .rd_entry(rd_entry)
  );

  assign busy             = done_r;
  assign out_strobe       = done_r;
  assign out_status       = status_r;
  assign out_cursor_valid = cur_ok;
  assign out_cursor_pos   = cur_ok ? cur_r[IDX_W-1:0] : '0;
  assign out_entry_count  = count_r;
  assign out_cur_key      = cur_ok ? rd_entry.key  : '0;
  assign out_cur_mask     = cur_ok ? rd_entry.mask : '0;
  assign out_cur_size     = cur_ok ? rd_entry.size : '0;

endmodule

[rtl/core/scle_port_checker.sv]
// Port-level checks for the sorted cursor list engine, bound to the top level.
// Depends on scle_pkg and the assertion macro header.
`include "sorted_cursor_list_engine_unit_assert.svh"

module scle_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic                          out_cursor_valid,
  input logic [scle_pkg::IDX_W-1:0]    out_cursor_pos,
  input logic [scle_pkg::CNT_W-1:0]    out_entry_count,
  input logic [scle_pkg::KEY_BITS-1:0] out_cur_key,
  input logic [scle_pkg::MASK_W-1:0]   out_cur_mask,
  input logic [scle_pkg::SIZE_W-1:0]   out_cur_size
);
  import scle_pkg::*;

  // each accepted word must give a result on the next cycle
  `SCLE_ASSERT_NEXT(a_one_result, clk, rst_n, start && !busy, out_strobe, "missing result")
  `SCLE_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy, "result outside busy cycle")
  `SCLE_ASSERT_NOW(a_idle_zero, clk, rst_n, out_strobe && !out_cursor_valid, (out_cursor_pos == '0) && (out_cur_key == '0) && (out_cur_mask == '0) && (out_cur_size == '0), "fields not zero without cursor")
  `SCLE_ASSERT_NOW(a_pos_in_list, clk, rst_n, out_strobe && out_cursor_valid, {1'b0, out_cursor_pos} < out_entry_count, "cursor beyond count")
  `SCLE_ASSERT_NOW(a_count_cap, clk, rst_n, out_strobe, out_entry_count <= CNT_W'(CAPACITY), "count above capacity")

endmodule

bind sorted_cursor_list_engine_unit scle_port_checker u_scle_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_cursor_valid(out_cursor_valid),
  .out_cursor_pos  (out_cursor_pos),
  .out_entry_count (out_entry_count),
  .out_cur_key     (out_cur_key),
  .out_cur_mask    (out_cur_mask),
  .out_cur_size    (out_cur_size)
);

[verif/tb_sorted_cursor_list_engine_unit.sv]
// Self-checking testbench for sorted_cursor_list_engine_unit: directed and random requests,
// each result checked against a shadow copy of the sorted list and its cursor.
// Depends on scle_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_sorted_cursor_list_engine_unit;
  import scle_pkg::*;

  // Request code left unused by the engine; it must leave everything untouched.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int IDLE_PCT = 21;

  typedef struct packed {
    status_t             status;
    logic                cursor_valid;
    logic [IDX_W-1:0]    cursor_pos;
    logic [CNT_W-1:0]    entry_count;
    logic [KEY_BITS-1:0] cur_key;
    logic [MASK_W-1:0]   cur_mask;
    logic [SIZE_W-1:0]   cur_size;
  } list_resp_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    in_req_type;
  logic [KEY_BITS-1:0] in_new_key;
  logic [MASK_W-1:0]   in_new_mask;
  logic [SIZE_W-1:0]   in_new_size;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic                out_cursor_valid;
  logic [IDX_W-1:0]    out_cursor_pos;
  logic [CNT_W-1:0]    out_entry_count;
  logic [KEY_BITS-1:0] out_cur_key;
  logic [MASK_W-1:0]   out_cur_mask;
  logic [SIZE_W-1:0]   out_cur_size;

  // Shadow copy of the list
  logic [KEY_BITS-1:0] shadow_key  [CAPACITY];
  logic [MASK_W-1:0]   shadow_mask [CAPACITY];
  logic [SIZE_W-1:0]   shadow_size [CAPACITY];
  int                  shadow_count  = 0;
  int                  shadow_cursor = -1;

  list_resp_t pending_resp_q[$];
  int         fail_cnt = 0;
  bit         idle_on  = 1'b1;

  sorted_cursor_list_engine_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_new_key       (in_new_key),
    .in_new_mask      (in_new_mask),
    .in_new_size      (in_new_size),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_cursor_valid (out_cursor_valid),
    .out_cursor_pos   (out_cursor_pos),
    .out_entry_count  (out_entry_count),
    .out_cur_key      (out_cur_key),
    .out_cur_mask     (out_cur_mask),
    .out_cur_size     (out_cur_size)
  );

  always #5 clk = ~clk;

  function automatic bit cursor_on_list();
    return shadow_cursor >= 0 && shadow_cursor < shadow_count;
  endfunction

  task automatic predict_list_response(input logic [REQ_W-1:0] req,
                                       input logic [KEY_BITS-1:0] key,
                                       input logic [MASK_W-1:0] mask,
                                       input logic [SIZE_W-1:0] size,
                                       output list_resp_t r);
    status_t st;
    int      pos;
    bit      on_list;
    st = ST_OK;
    on_list = cursor_on_list();
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          // equal keys: new entry lands ahead of the existing ones
          pos = 0;
          while (pos < shadow_count && key > shadow_key[pos]) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i]  = shadow_key[i-1];
            shadow_mask[i] = shadow_mask[i-1];
            shadow_size[i] = shadow_size[i-1];
          end
          shadow_key[pos]  = key;
          shadow_mask[pos] = mask;
          shadow_size[pos] = size;
          shadow_count++;
          shadow_cursor = shadow_count - 1;
        end
      end
      REQ_REMOVE: begin
        if (!on_list) begin
          st = ST_NOCUR;
        end else begin
          for (int i = shadow_cursor; i < shadow_count - 1; i++) begin
            shadow_key[i]  = shadow_key[i+1];
            shadow_mask[i] = shadow_mask[i+1];
            shadow_size[i] = shadow_size[i+1];
          end
          shadow_count--;
          // pull the cursor back onto the new last entry
          if (!cursor_on_list() && shadow_count > 0) shadow_cursor = shadow_count - 1;
        end
      end
      REQ_READ: begin
        if (!on_list) st = ST_NOCUR;
      end
      REQ_HEAD: begin
        if (shadow_count > 0) shadow_cursor = 0;
        else st = ST_NOCUR;
      end
      REQ_TAIL: begin
        if (shadow_count > 0) shadow_cursor = shadow_count - 1;
        else st = ST_NOCUR;
      end
      REQ_PREV: begin
        if (on_list) shadow_cursor--;
        else st = ST_NOCUR;
      end
      REQ_NEXT: begin
        if (on_list) shadow_cursor++;
        else st = ST_NOCUR;
      end
      default: ;
    endcase
    r = '0;
    r.status = st;
    r.entry_count = shadow_count[CNT_W-1:0];
    if (cursor_on_list()) begin
      r.cursor_valid = 1'b1;
      r.cursor_pos   = shadow_cursor[IDX_W-1:0];
      r.cur_key      = shadow_key[shadow_cursor];
      r.cur_mask     = shadow_mask[shadow_cursor];
      r.cur_size     = shadow_size[shadow_cursor];
    end
  endtask

  // Drive one request word and hold it until the engine takes it.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [KEY_BITS-1:0] key,
                           input logic [MASK_W-1:0] mask, input logic [SIZE_W-1:0] size);
    list_resp_t r;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start       = 1'b1;
    in_req_type = req;
    in_new_key  = key;
    in_new_mask = mask;
    in_new_size = size;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_response(req, key, mask, size, r);
    pending_resp_q.push_back(r);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_BITS'($urandom_range(100, 103));  // force duplicate keys
      default: return KEY_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] rand_req(input int ins_pct, input int rem_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return REQ_INSERT;
    if (roll < ins_pct + rem_pct) return REQ_REMOVE;
    case ($urandom_range(0, 10))
      0, 1:    return REQ_READ;
      2, 3:    return REQ_HEAD;
      4:       return REQ_TAIL;
      5, 6:    return REQ_PREV;
      7, 8, 9: return REQ_NEXT;
      default: return REQ_UNUSED;
    endcase
  endfunction

  task automatic send_random(input int ins_pct, input int rem_pct);
    send_item(rand_req(ins_pct, rem_pct), rand_key(), rand_mask(),
              SIZE_W'($urandom_range(0, 31)));
  endtask

  task automatic test_empty_list();
    send_item(REQ_READ,   '0, '0, '0);
    send_item(REQ_REMOVE, '0, '0, '0);
    send_item(REQ_PREV,   '0, '0, '0);
    send_item(REQ_NEXT,   '0, '0, '0);
    send_item(REQ_HEAD,   '0, '0, '0);
    send_item(REQ_TAIL,   '0, '0, '0);
    send_item(REQ_UNUSED, '1, '1, '1);
  endtask

  task automatic test_insert_order();
    send_item(REQ_INSERT, 8'h80, '0, 5'd0);
    send_item(REQ_INSERT, 8'h00, '1, 5'd31);
    send_item(REQ_INSERT, 8'hFF, 25'h1555555, 5'd25);
    send_item(REQ_INSERT, 8'h80, 25'h0AAAAAA, 5'd26);
  endtask

  task automatic test_cursor_moves();
    send_item(REQ_HEAD,   '0, '0, '0);
    send_item(REQ_PREV,   '0, '0, '0);  // step off the front
    send_item(REQ_NEXT,   '0, '0, '0);
    send_item(REQ_TAIL,   '0, '0, '0);
    send_item(REQ_NEXT,   '0, '0, '0);  // step off the back
    send_item(REQ_READ,   '0, '0, '0);
    send_item(REQ_HEAD,   '0, '0, '0);
    send_item(REQ_NEXT,   '0, '0, '0);
    send_item(REQ_UNUSED, '0, '0, '0);
  endtask

  task automatic test_remove_cases();
    send_item(REQ_TAIL,   '0, '0, '0);
    send_item(REQ_REMOVE, '0, '0, '0);  // cursor falls off and moves to the last entry
    send_item(REQ_HEAD,   '0, '0, '0);
    send_item(REQ_REMOVE, '0, '0, '0);
    send_item(REQ_REMOVE, '0, '0, '0);
    send_item(REQ_REMOVE, '0, '0, '0);  // only entry left
    send_item(REQ_REMOVE, '0, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_count < CAPACITY) send_random(85, 0);
    repeat (3) send_item(REQ_INSERT, rand_key(), rand_mask(), SIZE_W'($urandom_range(0, 31)));
    while (shadow_count > 0) send_random(0, 40);
  endtask

  task automatic test_random_mix();
    int ins_pct;
    int rem_pct;
    repeat (8) begin
      case ($urandom_range(0, 2))
        0:       begin ins_pct = 60; rem_pct = 10; end
        1:       begin ins_pct = 15; rem_pct = 40; end
        default: begin ins_pct = 30; rem_pct = 20; end
      endcase
      repeat (50) send_random(ins_pct, rem_pct);
    end
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    repeat (200) send_random(35, 20);
    idle_on = 1'b1;
  endtask

  task automatic test_pause_for_results();
    repeat (5) begin
      repeat (20) send_random(35, 20);
      wait_for_results();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    list_resp_t want;
    if (rst_n && out_strobe) begin
      if (pending_resp_q.size() == 0) begin
        $error("result word with no request outstanding");
        fail_cnt++;
      end else begin
        want = pending_resp_q.pop_front();
        check_field("out_status",       want.status,       out_status);
        check_field("out_cursor_valid", want.cursor_valid, out_cursor_valid);
        check_field("out_cursor_pos",   want.cursor_pos,   out_cursor_pos);
        check_field("out_entry_count",  want.entry_count,  out_entry_count);
        check_field("out_cur_key",      want.cur_key,      out_cur_key);
        check_field("out_cur_mask",     want.cur_mask,     out_cur_mask);
        check_field("out_cur_size",     want.cur_size,     out_cur_size);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = '0;
    in_new_key  = '0;
    in_new_mask = '0;
    in_new_size = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_insert_order();
    test_cursor_moves();
    test_remove_cases();
    test_fill_and_drain();
    test_random_mix();
    test_no_idle_stretch();
    test_pause_for_results();

    wait_for_results();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && pending_resp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
